>>> rtl/moie_pkg.sv
// Types, opcodes and codes shared by the instruction executor.
`timescale 1ns / 1ps
`default_nettype none
package moie_pkg;

  typedef struct packed {
    logic [6:0]  opcode;
    logic [2:0]  mode_a;
    logic [2:0]  mode_b;
    logic [2:0]  mode_c;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [15:0] operand_c;
    logic [15:0] next_ip;
    logic [7:0]  buttons;
  } in_item_t;

  typedef struct packed {
    logic [15:0] new_ip;
    logic        vsync_pulse;
    logic [2:0]  error_code;
  } out_item_t;

  localparam logic [6:0] OP_NONE  = 7'd0;
  localparam logic [6:0] OP_ADD   = 7'd1;
  localparam logic [6:0] OP_SUB   = 7'd2;
  localparam logic [6:0] OP_MUL   = 7'd3;
  localparam logic [6:0] OP_DIV   = 7'd4;
  localparam logic [6:0] OP_MOD   = 7'd5;
  localparam logic [6:0] OP_AND   = 7'd6;
  localparam logic [6:0] OP_OR    = 7'd7;
  localparam logic [6:0] OP_XOR   = 7'd8;
  localparam logic [6:0] OP_RS    = 7'd9;
  localparam logic [6:0] OP_LS    = 7'd10;
  localparam logic [6:0] OP_NOT   = 7'd11;
  localparam logic [6:0] OP_BEQ   = 7'd12;
  localparam logic [6:0] OP_JMP   = 7'd13;
  localparam logic [6:0] OP_VSYNC = 7'd14;
  localparam logic [6:0] OP_CALL  = 7'd15;
  localparam logic [6:0] OP_RET   = 7'd16;
  localparam logic [6:0] OP_BGT   = 7'd17;
  localparam logic [6:0] OP_BNE   = 7'd18;

  typedef enum logic [2:0] {
    ERR_OK, ERR_LIT, ERR_ROM, ERR_DIV0, ERR_OVF, ERR_UNF, ERR_OPC
  } err_t;

  typedef enum logic [1:0] {MD_MUL, MD_DIV, MD_MOD} md_op_t;

  typedef struct packed {
    logic   start;
    md_op_t op;
  } md_req_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_OP1, S_OP1R, S_OP2, S_OP2R, S_EXEC, S_MDW, S_DONE
  } state_t;

endpackage
`default_nettype wire

>>> rtl/moie_if.sv
// Valid/ready channel interfaces for instruction beats and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface moie_req_if import moie_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface moie_rsp_if import moie_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/memory_operand_instruction_executor_unit.sv
// Memory-to-memory instruction executor: one instruction beat in, one result beat out.
// Use: drive instruction beats on req; each yields one beat on rsp with the next ip,
// the vsync flag and an error code. Operands resolve through the data RAM, which
// has one read and one write port and a registered read, so each operand passes
// through two stages, S_OP1 and S_OP2, plus a wait state (S_OP1R or S_OP2R) for
// each RAM read, with up to two dependent RAM reads per operand. The instruction
// then executes in S_EXEC and loads the output register in S_DONE; mul, div and
// mod first wait in S_MDW on the bit-serial multiply/divide unit. One instruction
// is in flight at a time; the next is accepted no earlier than the cycle after the
// previous result is loaded into the output register.
// Reset: after rst the block sweeps the data RAM to zero, one word a cycle, for
// all RAM_WORDS words, with req.ready low; the button latch and the return stack
// depth clear at once.
// Stall: a result beat holds in the output register until rsp.ready; the next
// instruction may run meanwhile but will not finish until that beat is taken.
// Errors leave all state unchanged and return next_ip.
`timescale 1ns / 1ps
`default_nettype none
module memory_operand_instruction_executor_unit import moie_pkg::*; #(
  parameter int RAM_WORDS   = 65536,
  parameter int DATA_BITS   = 32,
  parameter int STACK_DEPTH = 16
) (
  input wire logic clk,
  input wire logic rst,
  moie_req_if.sink   req,
  moie_rsp_if.source rsp
);
  localparam int AW    = $clog2(RAM_WORDS);
  localparam int SP_W  = $clog2(STACK_DEPTH);
  localparam int DEP_W = $clog2(STACK_DEPTH + 1);

  function automatic logic [AW-1:0] ram_index(input logic [15:0] x);
    logic [31:0] v;
    logic [31:0] lim;
    v = 32'(x);
    for (int k = 7; k >= 0; k--) begin
      lim = 32'(RAM_WORDS) << k;
      if (lim <= 32'hFFFF && v >= lim) begin
        v = v - lim;
      end
    end
    return v[AW-1:0];
  endfunction

  state_t               state;
  state_t               state_next;
  in_item_t             item;
  logic [1:0]           opn;
  logic [DATA_BITS-1:0] cur;
  logic [DATA_BITS-1:0] opv [3];
  logic [15:0]          s1b;
  logic [15:0]          s1c;
  logic [AW-1:0]        clr;
  logic [7:0]           latch;
  logic [DEP_W-1:0]     depth;
  logic [15:0]          stack [STACK_DEPTH];
  logic [15:0]          stk_rd;
  logic                 out_valid;
  out_item_t            out_data;

  logic [DATA_BITS-1:0] res;
  logic                 wr;
  err_t                 err;
  logic [15:0]          nip;
  logic                 pulse;
  logic                 usb;
  logic                 push;
  logic                 pop;

  logic [DATA_BITS-1:0] x_res;
  logic                 x_wr;
  err_t                 x_err;
  logic [15:0]          x_ip;
  logic                 x_pulse;
  logic                 x_usb;
  logic                 x_push;
  logic                 x_pop;
  md_req_t              md_req;
  logic                 md_done;
  logic [DATA_BITS-1:0] md_res;

  logic [2:0]           m;
  logic [15:0]          w;
  logic [DATA_BITS-1:0] rd_data;
  logic [AW-1:0]        rd_addr;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [DATA_BITS-1:0] wdata;
  logic                 free;
  logic                 load;
  logic [2:0]           wm;
  logic [15:0]          ww;
  logic [15:0]          ws1;
  err_t                 derr;
  err_t                 fin_err;
  logic [AW-1:0]        slot;
  logic                 commit;
  logic [DATA_BITS-1:0] a;
  logic [DATA_BITS-1:0] b;
  logic [DATA_BITS-1:0] c;

  assign a = opv[0];
  assign b = opv[1];
  assign c = opv[2];

  always_comb begin
    case (opn)
      2'd0:    begin m = item.mode_a; w = item.operand_a; end
      2'd1:    begin m = item.mode_b; w = item.operand_b; end
      default: begin m = item.mode_c; w = item.operand_c; end
    endcase
  end

  assign rd_addr = (state == S_OP2) ? ram_index(cur[15:0]) : ram_index(w);

  // exec decode
  always_comb begin
    x_res   = '0;
    x_wr    = 1'b0;
    x_err   = ERR_OK;
    x_ip    = item.next_ip;
    x_pulse = 1'b0;
    x_usb   = 1'b0;
    x_push  = 1'b0;
    x_pop   = 1'b0;
    md_req  = '{start: 1'b0, op: MD_MUL};
    case (item.opcode)
      OP_NONE: ;
      OP_ADD: begin x_res = a + b; x_wr = 1'b1; end
      OP_SUB: begin x_res = a - b; x_wr = 1'b1; end
      OP_MUL: begin
        x_wr   = 1'b1;
        md_req = '{start: 1'b1, op: MD_MUL};
      end
      OP_DIV, OP_MOD: begin
        if (b == '0) begin
          x_err = ERR_DIV0;
        end else begin
          x_wr   = 1'b1;
          md_req = '{start: 1'b1, op: (item.opcode == OP_DIV) ? MD_DIV : MD_MOD};
        end
      end
      OP_AND: begin x_res = a & b; x_wr = 1'b1; end
      OP_OR:  begin x_res = a | b; x_wr = 1'b1; end
      OP_XOR: begin x_res = a ^ b; x_wr = 1'b1; end
      OP_RS:  begin x_res = DATA_BITS'($signed(a) >>> b[4:0]); x_wr = 1'b1; end
      OP_LS:  begin x_res = a << b[4:0]; x_wr = 1'b1; end
      OP_NOT: begin x_res = ~a; x_wr = 1'b1; x_usb = 1'b1; end
      OP_BEQ: begin
        if (a == b) begin
          x_ip = item.next_ip + c[15:0];
        end
      end
      OP_JMP:   x_ip = item.next_ip + a[15:0];
      OP_VSYNC: x_pulse = 1'b1;
      OP_CALL: begin
        if (depth >= DEP_W'(STACK_DEPTH)) begin
          x_err = ERR_OVF;
        end else begin
          x_push = 1'b1;
          x_ip   = item.next_ip + a[15:0];
        end
      end
      OP_RET: begin
        if (depth == '0) begin
          x_err = ERR_UNF;
        end else begin
          x_pop = 1'b1;
          x_ip  = stk_rd;
        end
      end
      OP_BGT: begin
        if ($signed(a) > $signed(b)) begin
          x_ip = item.next_ip + c[15:0];
        end
      end
      OP_BNE: begin
        if (a != b) begin
          x_ip = item.next_ip + c[15:0];
        end
      end
      default: x_err = ERR_OPC;
    endcase
    if (state != S_EXEC) begin
      md_req.start = 1'b0;
    end
  end

  // destination and commit
  always_comb begin
    wm   = usb ? item.mode_b : item.mode_c;
    ww   = usb ? item.operand_b : item.operand_c;
    ws1  = usb ? s1b : s1c;
    derr = ERR_OK;
    slot = ram_index(ww);
    if (wm == 3'd0) begin
      derr = ERR_LIT;
    end else if (wm[2]) begin
      slot = ram_index(ws1);
    end else if (wm[1]) begin
      derr = ERR_ROM;
    end
    if (err != ERR_OK) begin
      fin_err = err;
    end else if (wr) begin
      fin_err = derr;
    end else begin
      fin_err = ERR_OK;
    end
  end

  assign free   = !out_valid || rsp.ready;
  assign load   = (state == S_DONE) && free;
  assign commit = load && (fin_err == ERR_OK);

  assign we    = (state == S_CLEAR) || (commit && wr);
  assign waddr = (state == S_CLEAR) ? clr : slot;
  assign wdata = (state == S_CLEAR) ? '0 : res;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr == AW'(RAM_WORDS - 1)) state_next = S_IDLE;
      S_IDLE:  if (req.valid) state_next = S_OP1;
      S_OP1:   state_next = (m[0] && !m[1]) ? S_OP1R : S_OP2;
      S_OP1R:  state_next = S_OP2;
      S_OP2: begin
        if (m[2]) begin
          state_next = S_OP2R;
        end else begin
          state_next = (opn == 2'd2) ? S_EXEC : S_OP1;
        end
      end
      S_OP2R:  state_next = (opn == 2'd2) ? S_EXEC : S_OP1;
      S_EXEC:  state_next = md_req.start ? S_MDW : S_DONE;
      S_MDW:   if (md_done) state_next = S_DONE;
      S_DONE:  if (free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      latch     <= '0;
      depth     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_CLEAR) begin
        clr <= clr + 1'b1;
      end
      if (commit) begin
        if (pulse) begin
          latch <= item.buttons;
        end
        if (push) begin
          depth <= depth + 1'b1;
        end else if (pop) begin
          depth <= depth - 1'b1;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        item <= req.data;
        opn  <= 2'd0;
      end
      S_OP1: begin
        if (m[1]) begin
          cur <= (w == 16'd0) ? DATA_BITS'(latch) : '0;
        end else if (!m[0]) begin
          cur <= DATA_BITS'(w);
        end
      end
      S_OP1R: cur <= rd_data;
      S_OP2: begin
        if (opn == 2'd1) s1b <= cur[15:0];
        if (opn == 2'd2) s1c <= cur[15:0];
        if (!m[2]) begin
          opv[opn] <= cur;
          opn      <= opn + 1'b1;
        end
      end
      S_OP2R: begin
        opv[opn] <= rd_data;
        opn      <= opn + 1'b1;
      end
      S_EXEC: begin
        res   <= x_res;
        wr    <= x_wr;
        err   <= x_err;
        nip   <= x_ip;
        pulse <= x_pulse;
        usb   <= x_usb;
        push  <= x_push;
        pop   <= x_pop;
      end
      S_MDW: if (md_done) res <= md_res;
      default: ;
    endcase
    if (load) begin
      out_data.new_ip      <= (fin_err == ERR_OK) ? nip : item.next_ip;
      out_data.vsync_pulse <= (fin_err == ERR_OK) ? pulse : 1'b0;
      out_data.error_code  <= fin_err;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && push) begin
      stack[depth[SP_W-1:0]] <= item.next_ip;
    end
    stk_rd <= stack[SP_W'(depth - 1'b1)];
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  moie_ram #(.WORDS(RAM_WORDS), .WIDTH(DATA_BITS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  moie_md #(.DATA_BITS(DATA_BITS)) u_md (
    .clk    (clk),
    .rst    (rst),
    .req    (md_req),
    .a      (a),
    .b      (b),
    .done   (md_done),
    .result (md_res)
  );

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEP_W'(STACK_DEPTH))
    else $error("return stack depth out of range");

  a_md_in_wait: assert property (@(posedge clk) disable iff (rst)
    md_done |-> state == S_MDW)
    else $error("multiply/divide completion outside wait state");

  a_fault_result: assert property (@(posedge clk) disable iff (rst)
    load && fin_err != ERR_OK |=>
      !out_data.vsync_pulse && out_data.new_ip == $past(item.next_ip))
    else $error("faulting beat did not return next ip");
`endif
endmodule
`default_nettype wire

>>> rtl/moie_ram.sv
// Single-port-write, registered-read data memory.
`timescale 1ns / 1ps
`default_nettype none
module moie_ram #(
  parameter int WORDS = 65536,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(WORDS)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(WORDS)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/moie_md.sv
// Iterative shift-add multiplier and restoring signed divider, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module moie_md import moie_pkg::*; #(
  parameter int DATA_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire md_req_t              req,
  input  wire logic [DATA_BITS-1:0] a,
  input  wire logic [DATA_BITS-1:0] b,
  output logic                      done,
  output logic      [DATA_BITS-1:0] result
);
  localparam int CW = $clog2(DATA_BITS + 1);

  logic                 busy;
  logic [CW-1:0]        cnt;
  md_op_t               op;
  logic [DATA_BITS-1:0] r;
  logic [DATA_BITS-1:0] x;
  logic [DATA_BITS-1:0] y;
  logic                 na;
  logic                 nb;
  logic [DATA_BITS:0]   rem_s;
  logic [DATA_BITS:0]   diff;
  logic                 ge;
  logic [DATA_BITS-1:0] ma;
  logic [DATA_BITS-1:0] mb;

  assign ma    = a[DATA_BITS-1] ? (~a + 1'b1) : a;
  assign mb    = b[DATA_BITS-1] ? (~b + 1'b1) : b;
  assign rem_s = {r, x[DATA_BITS-1]};
  assign ge    = rem_s >= {1'b0, y};
  assign diff  = rem_s - {1'b0, y};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(DATA_BITS);
        op   <= req.op;
        na   <= a[DATA_BITS-1];
        nb   <= b[DATA_BITS-1];
        r    <= '0;
        if (req.op == MD_MUL) begin
          x <= a;
          y <= b;
        end else begin
          x <= ma;
          y <= mb;
        end
      end else if (busy) begin
        if (op == MD_MUL) begin
          if (y[0]) begin
            r <= r + x;
          end
          x <= x << 1;
          y <= y >> 1;
        end else begin
          r <= ge ? diff[DATA_BITS-1:0] : rem_s[DATA_BITS-1:0];
          x <= {x[DATA_BITS-2:0], ge};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    case (op)
      MD_MUL:  result = r;
      MD_DIV:  result = (na ^ nb) ? (~x + 1'b1) : x;
      MD_MOD:  result = na ? (~r + 1'b1) : r;
      default: result = r;
    endcase
  end
endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the memory-operand instruction executor.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import moie_pkg::*;

  localparam int MEM_WORDS = 65536;
  localparam int WORD_BITS = 32;
  localparam int RSTACK_DEPTH = 16;
  localparam int IDLE_LIMIT = 400000;

  typedef logic [WORD_BITS-1:0] word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic failed = 1'b0;

  moie_req_if req ();
  moie_rsp_if rsp ();

  memory_operand_instruction_executor_unit dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  word_t ram_shadow [MEM_WORDS];
  logic [7:0] button_shadow;
  logic [15:0] call_stack [RSTACK_DEPTH];
  int unsigned call_depth;
  out_item_t pending_results [$];
  int unsigned idle_cycles;
  logic stall_on;

  function automatic word_t read_operand(logic [2:0] mode, logic [15:0] w);
    word_t v;
    v = word_t'(w);
    if (mode[1]) v = (w == 16'd0) ? word_t'(button_shadow) : '0;
    else if (mode[0]) v = ram_shadow[w];
    if (mode[2]) v = ram_shadow[v[15:0]];
    return v;
  endfunction

  function automatic out_item_t execute(in_item_t it);
    out_item_t r;
    word_t a, b, c, res, ma, mb, q;
    logic [15:0] ip, slot, d;
    logic [2:0] wm;
    logic [15:0] ww;
    logic wr;
    err_t err;
    a = read_operand(it.mode_a, it.operand_a);
    b = read_operand(it.mode_b, it.operand_b);
    c = read_operand(it.mode_c, it.operand_c);
    ip = it.next_ip;
    r.new_ip = ip;
    r.vsync_pulse = 1'b0;
    err = ERR_OK;
    wr = 1'b0;
    res = '0;
    wm = it.mode_c;
    ww = it.operand_c;
    case (it.opcode)
      OP_NONE: ;
      OP_ADD: begin res = a + b; wr = 1'b1; end
      OP_SUB: begin res = a - b; wr = 1'b1; end
      OP_MUL: begin res = a * b; wr = 1'b1; end
      OP_DIV, OP_MOD: begin
        ma = a[WORD_BITS-1] ? -a : a;
        mb = b[WORD_BITS-1] ? -b : b;
        if (b == '0) err = ERR_DIV0;
        else begin
          if (it.opcode == OP_DIV) begin
            q = ma / mb;
            res = (a[WORD_BITS-1] != b[WORD_BITS-1]) ? -q : q;
          end else begin
            q = ma % mb;
            res = a[WORD_BITS-1] ? -q : q;
          end
          wr = 1'b1;
        end
      end
      OP_AND: begin res = a & b; wr = 1'b1; end
      OP_OR: begin res = a | b; wr = 1'b1; end
      OP_XOR: begin res = a ^ b; wr = 1'b1; end
      OP_RS: begin res = $signed(a) >>> b[4:0]; wr = 1'b1; end
      OP_LS: begin res = a << b[4:0]; wr = 1'b1; end
      OP_NOT: begin
        res = ~a; wr = 1'b1; wm = it.mode_b; ww = it.operand_b;
      end
      OP_BEQ: if (a == b) r.new_ip = ip + c[15:0];
      OP_JMP: r.new_ip = ip + a[15:0];
      OP_VSYNC: begin button_shadow = it.buttons; r.vsync_pulse = 1'b1; end
      OP_CALL: begin
        if (call_depth >= RSTACK_DEPTH) err = ERR_OVF;
        else begin
          call_stack[call_depth] = ip;
          call_depth++;
          r.new_ip = ip + a[15:0];
        end
      end
      OP_RET: begin
        if (call_depth == 0) err = ERR_UNF;
        else begin
          call_depth--;
          r.new_ip = call_stack[call_depth];
        end
      end
      OP_BGT: if ($signed(a) > $signed(b)) r.new_ip = ip + c[15:0];
      OP_BNE: if (a != b) r.new_ip = ip + c[15:0];
      default: err = ERR_OPC;
    endcase
    if (err == ERR_OK && wr) begin
      d = ww;
      if (wm == 3'd0) err = ERR_LIT;
      else if (wm[2]) begin
        if (wm[1]) d = (ww == 16'd0) ? 16'(button_shadow) : 16'd0;
        else if (wm[0]) d = ram_shadow[ww][15:0];
      end else if (wm[1]) err = ERR_ROM;
      slot = d;
      if (err == ERR_OK) ram_shadow[slot] = res;
    end
    if (err != ERR_OK) begin
      r.new_ip = ip;
      r.vsync_pulse = 1'b0;
    end
    r.error_code = err;
    return r;
  endfunction

  task automatic send_beat(in_item_t it);
    req.data <= it;
    req.valid <= 1'b1;
    do @(posedge clk); while (!req.ready);
    pending_results = {pending_results, execute(it)};
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end else if ($urandom_range(0, 7) == 0) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        failed <= 1'b1;
      end else begin
        exp_r = pending_results.pop_front();
        if (rsp.data.new_ip !== exp_r.new_ip) begin
          $error("new_ip expected %h actual %h", exp_r.new_ip, rsp.data.new_ip);
          failed <= 1'b1;
        end
        if (rsp.data.vsync_pulse !== exp_r.vsync_pulse) begin
          $error("vsync_pulse expected %b actual %b", exp_r.vsync_pulse,
                 rsp.data.vsync_pulse);
          failed <= 1'b1;
        end
        if (rsp.data.error_code !== exp_r.error_code) begin
          $error("error_code expected %0d actual %0d", exp_r.error_code,
                 rsp.data.error_code);
          failed <= 1'b1;
        end
      end
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
    rsp.ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic [6:0] op, logic [2:0] ma, logic [2:0] mb,
                                         logic [2:0] mc, logic [15:0] a, logic [15:0] b,
                                         logic [15:0] c);
    in_item_t it;
    it.opcode = op; it.mode_a = ma; it.mode_b = mb; it.mode_c = mc;
    it.operand_a = a; it.operand_b = b; it.operand_c = c;
    it.next_ip = 16'($urandom);
    it.buttons = 8'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] pick_addr();
    return $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 15));
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    logic [6:0] op;
    op = ($urandom_range(0, 19) == 0) ? 7'($urandom) : 7'($urandom_range(0, 18));
    if (op == OP_RET && call_depth == 0 && $urandom_range(0, 3) != 0) op = OP_CALL;
    it = make_item(op, 3'($urandom), 3'($urandom), 3'($urandom),
                   $urandom_range(0, 1) ? pick_addr() : 16'($urandom),
                   $urandom_range(0, 1) ? pick_addr() : 16'($urandom), pick_addr());
    if ($urandom_range(0, 2) != 0) it.mode_c = 3'($urandom_range(0, 1) ? 1 : 5);
    return it;
  endfunction

  task automatic test_extremes();
    send_beat(make_item(OP_ADD, 3'd0, 3'd0, 3'd1, 16'hFFFF, 16'hFFFF, 16'd1));
    send_beat(make_item(OP_SUB, 3'd0, 3'd0, 3'd1, 16'd0, 16'hFFFF, 16'd2));
    send_beat(make_item(OP_MUL, 3'd1, 3'd1, 3'd1, 16'd1, 16'd2, 16'd3));
    send_beat(make_item(OP_DIV, 3'd1, 3'd0, 3'd1, 16'd2, 16'd7, 16'd4));
    send_beat(make_item(OP_MOD, 3'd1, 3'd0, 3'd1, 16'd2, 16'd7, 16'd5));
    send_beat(make_item(OP_DIV, 3'd0, 3'd0, 3'd1, 16'd5, 16'd0, 16'd6));
    send_beat(make_item(OP_MOD, 3'd0, 3'd1, 3'd0, 16'd5, 16'd100, 16'd6));
    send_beat(make_item(OP_AND, 3'd0, 3'd0, 3'd0, 16'h00FF, 16'h0F0F, 16'd7));
    send_beat(make_item(OP_OR, 3'd0, 3'd0, 3'd2, 16'h00FF, 16'h0F0F, 16'd7));
    send_beat(make_item(OP_XOR, 3'd0, 3'd0, 3'd4, 16'h00FF, 16'h0F0F, 16'd8));
    send_beat(make_item(OP_RS, 3'd1, 3'd0, 3'd1, 16'd2, 16'd31, 16'd9));
    send_beat(make_item(OP_LS, 3'd0, 3'd0, 3'd5, 16'h8001, 16'hFFFF, 16'd9));
    send_beat(make_item(OP_NOT, 3'd0, 3'd1, 3'd0, 16'd0, 16'd10, 16'd0));
    send_beat(make_item(OP_NOT, 3'd0, 3'd3, 3'd0, 16'd0, 16'd10, 16'd0));
    send_beat(make_item(OP_VSYNC, 3'd0, 3'd0, 3'd0, 16'd0, 16'd0, 16'd0));
    send_beat(make_item(OP_ADD, 3'd2, 3'd6, 3'd6, 16'd0, 16'd0, 16'd0));
    send_beat(make_item(OP_BEQ, 3'd0, 3'd0, 3'd0, 16'd3, 16'd3, 16'h8000));
    send_beat(make_item(OP_BGT, 3'd1, 3'd0, 3'd0, 16'd10, 16'd0, 16'h7FFF));
    send_beat(make_item(OP_BNE, 3'd7, 3'd0, 3'd0, 16'd0, 16'd1, 16'hFFFF));
    send_beat(make_item(OP_JMP, 3'd0, 3'd0, 3'd0, 16'hFFFF, 16'd0, 16'd0));
    send_beat(make_item(OP_RET, 3'd0, 3'd0, 3'd0, 16'd0, 16'd0, 16'd0));
    send_beat(make_item(7'd19, 3'd0, 3'd0, 3'd0, 16'd0, 16'd0, 16'd0));
    send_beat(make_item(7'h7F, 3'd7, 3'd7, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_beat(make_item(OP_NONE, 3'd7, 3'd7, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
  endtask

  task automatic test_stack_limits();
    repeat (RSTACK_DEPTH + 1)
      send_beat(make_item(OP_CALL, 3'd0, 3'd0, 3'd0, 16'($urandom), 16'd0, 16'd0));
    repeat (RSTACK_DEPTH + 1)
      send_beat(make_item(OP_RET, 3'd0, 3'd0, 3'd0, 16'd0, 16'd0, 16'd0));
  endtask

  task automatic test_random();
    repeat (1260) send_beat(random_item());
  endtask

  initial begin
    foreach (ram_shadow[i]) ram_shadow[i] = '0;
    button_shadow = '0;
    call_depth = 0;
    stall_on = 1'b0;
    req.valid = 1'b0;
    req.data = '0;
    rsp.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_stack_limits();
    test_random();
    drain();
    if (!failed) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
